@@ hdl/rdt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rdt_pkg;

  // Default sizes of the tracker
  localparam int unsigned TableDepthDef = 64;
  localparam int unsigned ReadsMaxDef   = 16;
  localparam int unsigned IdBitsDef     = 32;
  localparam int unsigned DrawBitsDef   = 16;

  // Access kinds
  localparam logic ReqRead  = 1'b0;
  localparam logic ReqWrite = 1'b1;

  // Result of the shared table compare unit
  typedef struct packed {
    logic hit;   // key matched the entry at hit_idx
    logic miss;  // every filled entry compared, no match
  } scan_stat_t;

endpackage

`default_nettype wire

@@ hdl/read_after_write_dependency_tracker.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// request   in         in_valid_i / in_stall_o  draw_index, resource_id, req_type,
//                                              ends_draw, new_pass
// node      out        out_valid_o / out_stall_i job_id, has_dependency, producer,
//                                              final_node, overflow
//
// A read request is buffered in the pending read RAM while it has room. A write request
// uses the single compare unit to walk the filled entries, one table RAM read a cycle.
// A request that ends a draw call then resolves each buffered read with the same walk
// and closes the draw call.
// Reset clears the fill count, the read count and the overflow flag; no clearing pass.
// in_stall_o is high while a request is in work; a stalled node holds and pauses the walk.
module read_after_write_dependency_tracker
  import rdt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDef,
  parameter int unsigned READS_MAX   = ReadsMaxDef,
  parameter int unsigned ID_BITS     = IdBitsDef,
  parameter int unsigned DRAW_BITS   = DrawBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Request channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [DRAW_BITS-1:0] draw_index_i,
  input  wire logic [ID_BITS-1:0]   resource_id_i,
  input  wire logic                 req_type_i,
  input  wire logic                 ends_draw_i,
  input  wire logic                 new_pass_i,
  // Node channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [DRAW_BITS-1:0] job_id_o,
  output logic                      has_dependency_o,
  output logic      [DRAW_BITS-1:0] producer_o,
  output logic                      final_node_o,
  output logic                      overflow_o
);

  localparam int unsigned TAW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned TCW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PAW = (READS_MAX > 1) ? $clog2(READS_MAX) : 1;
  localparam int unsigned PCW = $clog2(READS_MAX + 1);
  localparam int unsigned TW  = ID_BITS + DRAW_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WSCAN,
    ST_RFETCH,
    ST_RLOAD,
    ST_RSCAN,
    ST_REMIT,
    ST_RFINAL
  } state_e;

  state_e               state_q, state_d;
  logic [DRAW_BITS-1:0] draw_q, draw_d;
  logic [ID_BITS-1:0]   key_q, key_d;
  logic                 ends_q, ends_d;
  logic [TCW-1:0]       count_q, count_d;
  logic [PCW-1:0]       pend_cnt_q, pend_cnt_d;
  logic [PCW-1:0]       rd_idx_q, rd_idx_d;
  logic                 ovf_q, ovf_d;
  logic                 held_vld_q, held_vld_d;
  logic [DRAW_BITS-1:0] held_prod_q, held_prod_d;
  logic [DRAW_BITS-1:0] found_q, found_d;
  logic                 out_vld_q, out_vld_d;
  logic [DRAW_BITS-1:0] out_job_q, out_job_d;
  logic                 out_dep_q, out_dep_d;
  logic [DRAW_BITS-1:0] out_prod_q, out_prod_d;
  logic                 out_fin_q, out_fin_d;
  logic                 out_ovf_q, out_ovf_d;

  // Table RAM: {resource, last writer draw}
  logic                 tbl_we;
  logic [TAW-1:0]       tbl_waddr;
  logic                 tbl_re;
  logic [TAW-1:0]       tbl_raddr;
  logic [TW-1:0]        tbl_rdata;
  logic [ID_BITS-1:0]   tbl_rd_res;
  logic [DRAW_BITS-1:0] tbl_rd_draw;

  // Pending read buffer RAM
  logic                 pend_we;
  logic                 pend_re;
  logic [ID_BITS-1:0]   pend_rdata;

  logic                 scan_run;
  scan_stat_t           scan_stat;
  logic [TAW-1:0]       hit_idx;
  logic                 out_free;

  assign tbl_rd_res  = tbl_rdata[TW-1:DRAW_BITS];
  assign tbl_rd_draw = tbl_rdata[DRAW_BITS-1:0];

  rdt_ram #(
    .WIDTH (TW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i ({key_q, draw_q}),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  rdt_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (READS_MAX)
  ) u_pending (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (pend_cnt_q[PAW-1:0]),
    .wdata_i (resource_id_i),
    .re_i    (pend_re),
    .raddr_i (rd_idx_q[PAW-1:0]),
    .rdata_o (pend_rdata)
  );

  rdt_scan #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .run_i     (scan_run),
    .key_i     (key_q),
    .count_i   (count_q),
    .rd_en_o   (tbl_re),
    .rd_addr_o (tbl_raddr),
    .rd_res_i  (tbl_rd_res),
    .stat_o    (scan_stat),
    .hit_idx_o (hit_idx)
  );

  // The output register can take a node when empty or draining this cycle
  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d     = state_q;
    draw_d      = draw_q;
    key_d       = key_q;
    ends_d      = ends_q;
    count_d     = count_q;
    pend_cnt_d  = pend_cnt_q;
    rd_idx_d    = rd_idx_q;
    ovf_d       = ovf_q;
    held_vld_d  = held_vld_q;
    held_prod_d = held_prod_q;
    found_d     = found_q;
    out_vld_d   = out_vld_q && out_stall_i;
    out_job_d   = out_job_q;
    out_dep_d   = out_dep_q;
    out_prod_d  = out_prod_q;
    out_fin_d   = out_fin_q;
    out_ovf_d   = out_ovf_q;
    tbl_we      = 1'b0;
    tbl_waddr   = count_q[TAW-1:0];
    pend_we     = 1'b0;
    pend_re     = 1'b0;
    scan_run    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          draw_d = draw_index_i;
          key_d  = resource_id_i;
          ends_d = ends_draw_i;
          // New pass: drop all table entries and the overflow flag first
          if (new_pass_i) begin
            count_d = '0;
            ovf_d   = 1'b0;
          end
          rd_idx_d = '0;
          if (req_type_i == ReqWrite) begin
            state_d = ST_WSCAN;
          end else begin
            if (pend_cnt_q < PCW'(READS_MAX)) begin
              pend_we    = 1'b1;
              pend_cnt_d = pend_cnt_q + PCW'(1);
            end else begin
              ovf_d = 1'b1;
            end
            state_d = ends_draw_i ? ST_RFETCH : ST_IDLE;
          end
        end
      end

      ST_WSCAN: begin
        scan_run = 1'b1;
        if (scan_stat.hit) begin
          // Known resource: replace its writer
          tbl_we    = 1'b1;
          tbl_waddr = hit_idx;
          state_d   = ends_q ? ST_RFETCH : ST_IDLE;
        end else if (scan_stat.miss) begin
          if (count_q < TCW'(TABLE_DEPTH)) begin
            tbl_we  = 1'b1;
            count_d = count_q + TCW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          state_d = ends_q ? ST_RFETCH : ST_IDLE;
        end
      end

      ST_RFETCH: begin
        if (rd_idx_q < pend_cnt_q) begin
          pend_re = 1'b1;
          state_d = ST_RLOAD;
        end else begin
          state_d = ST_RFINAL;
        end
      end

      ST_RLOAD: begin
        key_d   = pend_rdata;
        state_d = ST_RSCAN;
      end

      ST_RSCAN: begin
        scan_run = 1'b1;
        if (scan_stat.hit) begin
          found_d = tbl_rd_draw;
          state_d = ST_REMIT;
        end else if (scan_stat.miss) begin
          rd_idx_d = rd_idx_q + PCW'(1);
          state_d  = ST_RFETCH;
        end
      end

      ST_REMIT: begin
        // Hold one node back so the last one can carry the final mark
        if (!held_vld_q) begin
          held_vld_d  = 1'b1;
          held_prod_d = found_q;
          rd_idx_d    = rd_idx_q + PCW'(1);
          state_d     = ST_RFETCH;
        end else if (out_free) begin
          out_vld_d   = 1'b1;
          out_job_d   = draw_q;
          out_dep_d   = 1'b1;
          out_prod_d  = held_prod_q;
          out_fin_d   = 1'b0;
          out_ovf_d   = ovf_q;
          held_prod_d = found_q;
          rd_idx_d    = rd_idx_q + PCW'(1);
          state_d     = ST_RFETCH;
        end
      end

      ST_RFINAL: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_job_d  = draw_q;
          out_dep_d  = held_vld_q;
          out_prod_d = held_vld_q ? held_prod_q : '0;
          out_fin_d  = 1'b1;
          out_ovf_d  = ovf_q;
          held_vld_d = 1'b0;
          pend_cnt_d = '0;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      pend_cnt_q  <= '0;
      rd_idx_q    <= '0;
      ovf_q       <= 1'b0;
      held_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
      ends_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_cnt_q  <= pend_cnt_d;
      rd_idx_q    <= rd_idx_d;
      ovf_q       <= ovf_d;
      held_vld_q  <= held_vld_d;
      out_vld_q   <= out_vld_d;
      ends_q      <= ends_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    draw_q      <= draw_d;
    key_q       <= key_d;
    held_prod_q <= held_prod_d;
    found_q     <= found_d;
    out_job_q   <= out_job_d;
    out_dep_q   <= out_dep_d;
    out_prod_q  <= out_prod_d;
    out_fin_q   <= out_fin_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_valid_o      = out_vld_q;
  assign job_id_o         = out_job_q;
  assign has_dependency_o = out_dep_q;
  assign producer_o       = out_prod_q;
  assign final_node_o     = out_fin_q;
  assign overflow_o       = out_ovf_q;

endmodule

`default_nettype wire

@@ hdl/rdt_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rdt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/rdt_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Shared compare unit: walk the filled table entries one read per cycle and
// compare the registered read data against the key.
module rdt_scan
  import rdt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDef,
  parameter int unsigned ID_BITS     = IdBitsDef,
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               run_i,
  input  wire logic [ID_BITS-1:0] key_i,
  input  wire logic [CW-1:0]      count_i,
  output logic                    rd_en_o,
  output logic      [AW-1:0]      rd_addr_o,
  input  wire logic [ID_BITS-1:0] rd_res_i,
  output scan_stat_t              stat_o,
  output logic      [AW-1:0]      hit_idx_o
);

  logic [CW-1:0] ptr_q, ptr_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic [AW-1:0] cmp_idx_q, cmp_idx_d;
  logic          issue;

  assign issue     = run_i && (ptr_q < count_i);
  assign rd_en_o   = issue;
  assign rd_addr_o = ptr_q[AW-1:0];

  always_comb begin
    // Restart from entry zero whenever the unit is not running
    ptr_d     = run_i ? (ptr_q + CW'(issue)) : '0;
    cmp_vld_d = issue;
    cmp_idx_d = issue ? ptr_q[AW-1:0] : cmp_idx_q;
  end

  assign stat_o.hit  = run_i && cmp_vld_q && (rd_res_i == key_i);
  assign stat_o.miss = run_i && !cmp_vld_q && !issue;
  assign hit_idx_o   = cmp_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
    end else begin
      ptr_q     <= ptr_d;
      cmp_vld_q <= cmp_vld_d;
      cmp_idx_q <= cmp_idx_d;
    end
  end

endmodule

`default_nettype wire
